>>> design/c8alu_pkg.sv
// ----------------------------------------------------------------------------
// c8alu_pkg: shared types and codes for the 8-bit ALU and flags unit
// Operation codes, status bit positions and the request/response structs.
// ----------------------------------------------------------------------------
package c8alu_pkg;

    localparam logic [3:0] FN_ADC = 4'd0;
    localparam logic [3:0] FN_SBC = 4'd1;
    localparam logic [3:0] FN_AND = 4'd2;
    localparam logic [3:0] FN_ORA = 4'd3;
    localparam logic [3:0] FN_EOR = 4'd4;
    localparam logic [3:0] FN_BIT = 4'd5;
    localparam logic [3:0] FN_CMP = 4'd6;
    localparam logic [3:0] FN_AXS = 4'd7;
    localparam logic [3:0] FN_ASL = 4'd8;
    localparam logic [3:0] FN_LSR = 4'd9;
    localparam logic [3:0] FN_ROL = 4'd10;
    localparam logic [3:0] FN_ROR = 4'd11;
    localparam logic [3:0] FN_INC = 4'd12;
    localparam logic [3:0] FN_DEC = 4'd13;

    // status byte bit positions
    localparam int unsigned FLG_C = 0;
    localparam int unsigned FLG_Z = 1;
    localparam int unsigned FLG_V = 6;
    localparam int unsigned FLG_N = 7;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] left_value;
        logic [7:0] index_value;
        logic [7:0] operand;
        logic [7:0] flags_in;
    } t_alu_req;

    typedef struct packed {
        logic [7:0] result_value;
        logic [7:0] flags_out;
    } t_alu_rsp;

endpackage

>>> design/c8alu_core.sv
// ----------------------------------------------------------------------------
// c8alu_core: ALU datapath and flag logic
// Pure combinational evaluation of one registered request.
// ----------------------------------------------------------------------------
module c8alu_core
    import c8alu_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [7:0] a, m, p;
    logic       cin;
    logic [8:0] sum_adc;
    logic [8:0] dif_sbc;
    logic [7:0] cmp_lhs;
    logic [8:0] dif_cmp;
    logic [7:0] r;
    logic [7:0] q;

    assign a   = i_req.left_value;
    assign m   = i_req.operand;
    assign p   = i_req.flags_in;
    assign cin = p[FLG_C];

    assign sum_adc = {1'b0, a} + {1'b0, m} + {8'd0, cin};
    assign dif_sbc = {1'b0, a} - {1'b0, m} - {8'd0, ~cin};
    // cmp uses the left register, axs the AND of left and X
    assign cmp_lhs = (i_req.func == FN_AXS) ? (a & i_req.index_value) : a;
    assign dif_cmp = {1'b0, cmp_lhs} - {1'b0, m};

    always_comb begin
        r = a;
        q = p;
        unique case (i_req.func)
            FN_ADC: begin
                r        = sum_adc[7:0];
                q[FLG_C] = sum_adc[8];
                q[FLG_V] = ~(a[7] ^ m[7]) & (a[7] ^ sum_adc[7]);
            end
            FN_SBC: begin
                r        = dif_sbc[7:0];
                q[FLG_C] = ~dif_sbc[8];
                q[FLG_V] = (a[7] ^ dif_sbc[7]) & (a[7] ^ m[7]);
            end
            FN_AND: r = a & m;
            FN_ORA: r = a | m;
            FN_EOR: r = a ^ m;
            FN_BIT: r = a;
            FN_CMP: begin
                r        = a;
                q[FLG_C] = ~dif_cmp[8];
            end
            FN_AXS: begin
                r        = dif_cmp[7:0];
                q[FLG_C] = ~dif_cmp[8];
            end
            FN_ASL: begin
                r        = {m[6:0], 1'b0};
                q[FLG_C] = m[7];
            end
            FN_LSR: begin
                r        = {1'b0, m[7:1]};
                q[FLG_C] = m[0];
            end
            FN_ROL: begin
                r        = {m[6:0], cin};
                q[FLG_C] = m[7];
            end
            FN_ROR: begin
                r        = {cin, m[7:1]};
                q[FLG_C] = m[0];
            end
            FN_INC: r = m + 8'd1;
            FN_DEC: r = m - 8'd1;
            default: begin
                r = a;
                q = p;
            end
        endcase

        // Z/N: bit tests the AND and copies operand bits; cmp takes the difference; other defined codes take the result
        if (i_req.func == FN_BIT) begin
            q[FLG_Z] = ((a & m) == 8'd0);
            q[FLG_N] = m[7];
            q[FLG_V] = m[6];
        end else if (i_req.func == FN_CMP) begin
            q[FLG_Z] = (dif_cmp[7:0] == 8'd0);
            q[FLG_N] = dif_cmp[7];
        end else if (i_req.func <= FN_DEC) begin
            q[FLG_Z] = (r == 8'd0);
            q[FLG_N] = r[7];
        end
    end

    assign o_rsp.result_value = r;
    assign o_rsp.flags_out    = q;

endmodule

>>> design/cpu8_alu_flags_unit.sv
// ----------------------------------------------------------------------------
// cpu8_alu_flags_unit: 8-bit processor ALU with status flag update
// Binary add/subtract, logic, bit test, compare, AND-X-subtract, shifts,
// rotates, increment and decrement. Decimal mode is not implemented.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer when        Payload
// -------   ---------  -------------------  ---------------------------------
// command   in         start && !busy       func, left/index value, operand,
//                                           flags_in
// result    out        o_done (one cycle)   result_value, flags_out
//
// Cycles: one item per clock. A command that is taken is latched in the
//   request register, evaluated by the core, registered in the result
//   register and then driven on the result ports.
// busy is tied low: the valid bits of both stages advance every cycle; payloads load only with a valid item.
// Reset (synchronous, active low) clears only the valid bits of both stages.
// The receiver cannot stall; a result strobe lasts exactly one cycle.
//
module cpu8_alu_flags_unit
    import c8alu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] i_func,
    input  logic [7:0] i_left_value,
    input  logic [7:0] i_index_value,
    input  logic [7:0] i_operand,
    input  logic [7:0] i_flags_in,
    output logic       o_done,
    output logic [7:0] o_result_value,
    output logic [7:0] o_flags_out
);

    logic     r_req_vld;
    t_alu_req r_req;
    t_alu_req n_req;
    logic     r_rsp_vld;
    t_alu_rsp r_rsp;
    t_alu_rsp n_rsp;
    logic     take;

    assign busy = 1'b0;
    assign take = start & ~busy;

    assign n_req.func        = i_func;
    assign n_req.left_value  = i_left_value;
    assign n_req.index_value = i_index_value;
    assign n_req.operand     = i_operand;
    assign n_req.flags_in    = i_flags_in;

    // request stage: control bit reset, payload loaded on a command transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= n_req;
        end
    end

    c8alu_core u_core (
        .i_req (r_req),
        .o_rsp (n_rsp)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else begin
            r_rsp_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done         = r_rsp_vld;
    assign o_result_value = r_rsp.result_value;
    assign o_flags_out    = r_rsp.flags_out;

    // a strobe follows every command transfer unless reset intervenes
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take ##1 i_rst_n |=> o_done)
        else $error("result strobe missing after command transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_req_vld))
        else $error("result strobe without a request in flight");

    // bit and cmp leave the left register value unchanged
    a_cmp_keeps_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && (r_req.func == FN_BIT || r_req.func == FN_CMP))
        |=> (o_result_value == $past(r_req.left_value)))
        else $error("bit/cmp altered the result value");

    // unused codes pass the status byte straight through
    a_unused_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_vld && r_req.func > FN_DEC)
        |=> (o_flags_out == $past(r_req.flags_in)))
        else $error("unused operation changed the status byte");

endmodule
